// ----- hdl/uri_percent_encoder_modes_core_assert.svh -----
// assertion macros shared by the percent encoder checker
`ifndef URI_PERCENT_ENCODER_MODES_CORE_ASSERT_SVH
`define URI_PERCENT_ENCODER_MODES_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define UPE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("upe check failed: same-cycle rule");

// next-cycle implication, sampled on clk_i, off while in reset
`define UPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("upe check failed: next-cycle rule");

`endif

// ----- hdl/upe_pkg.sv -----
// types, character constants and class functions of the percent encoder
`timescale 1ns / 1ps

package upe_pkg;

  localparam int unsigned MaxBytes = 7;

  localparam logic [7:0] CharPct  = 8'h25;
  localparam logic [7:0] CharTwo  = 8'h32;
  localparam logic [7:0] CharFive = 8'h35;

  // character class modes
  localparam logic [2:0] ModeUser     = 3'd0;
  localparam logic [2:0] ModeHeader   = 3'd1;
  localparam logic [2:0] ModePassword = 3'd2;
  localparam logic [2:0] ModeHost     = 3'd3;
  localparam logic [2:0] ModeToken    = 3'd4;
  localparam logic [2:0] ModeTtl      = 3'd5;

  // pending escape state, one-hot
  typedef enum logic [2:0] {
    HeldNone  = 3'b001,
    HeldPct   = 3'b010,
    HeldDigit = 3'b100
  } upe_held_e;

  // burst of encoded bytes produced by one input byte, first byte lowest
  typedef struct packed {
    logic [8*MaxBytes-1:0] bytes;
    logic [2:0]            len;
    logic                  last;
  } upe_burst_t;

  function automatic logic is_num_char(input logic [7:0] c);
    is_num_char = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = is_num_char(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = is_num_char(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // alphanum plus mark characters - _ . ! ~ * ' ( )
  function automatic logic is_plain_char(input logic [7:0] c);
    is_plain_char = is_alnum(c) || (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E) ||
                    (c == 8'h21) || (c == 8'h7E) || (c == 8'h2A) || (c == 8'h27) ||
                    (c == 8'h28) || (c == 8'h29);
  endfunction

  // byte passes unchanged under the given mode
  function automatic logic allowed(input logic [2:0] mode, input logic [7:0] c);
    logic res;
    case (mode)
      ModeUser: begin
        res = is_plain_char(c) || (c == 8'h26) || (c == 8'h3D) || (c == 8'h2B) ||
              (c == 8'h24) || (c == 8'h2C) || (c == 8'h3B) || (c == 8'h3F) ||
              (c == 8'h2F);
      end
      ModeHeader: begin
        res = is_plain_char(c) || (c == 8'h5B) || (c == 8'h5D) || (c == 8'h2F) ||
              (c == 8'h3F) || (c == 8'h3A) || (c == 8'h2B) || (c == 8'h24);
      end
      ModePassword: begin
        res = is_plain_char(c) || (c == 8'h26) || (c == 8'h3D) || (c == 8'h2B) ||
              (c == 8'h24) || (c == 8'h2C);
      end
      ModeHost: begin
        res = is_alnum(c) || (c == 8'h2E) || (c == 8'h3A) || (c == 8'h5B) ||
              (c == 8'h5D) || (c == 8'h2D);
      end
      ModeTtl: begin
        res = is_num_char(c);
      end
      default: begin
        // token mode, also the unused codes
        res = is_alnum(c) || (c == 8'h2D) || (c == 8'h2E) || (c == 8'h21) ||
              (c == CharPct) || (c == 8'h2A) || (c == 8'h5F) || (c == 8'h2B) ||
              (c == 8'h60) || (c == 8'h27) || (c == 8'h7E);
      end
    endcase
    allowed = res;
  endfunction

  // upper-case hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

endpackage

// ----- hdl/upe_expand.sv -----
// expansion of one input byte into its burst of encoded bytes
`timescale 1ns / 1ps

module upe_expand (
  input  logic [2:0]         mode_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  upe_pkg::upe_held_e held_i,
  input  logic [7:0]         digit_i,
  output upe_pkg::upe_held_e held_o,
  output logic [7:0]         digit_o,
  output upe_pkg::upe_burst_t burst_o
);

  logic               hex;
  logic               esc_mode;
  logic               pass;
  logic               do_fresh;
  logic [31:0]        pre_vec;
  logic [2:0]         pre_len;
  logic [23:0]        fr_vec;
  logic [2:0]         fr_len;
  logic [31:0]        fl_vec;
  logic [2:0]         fl_len;
  logic [2:0]         head_len;
  upe_pkg::upe_held_e held_mid;
  logic [7:0]         digit_mid;

  assign hex      = upe_pkg::is_hex(byte_i);
  assign esc_mode = (mode_i <= upe_pkg::ModePassword);
  assign pass     = upe_pkg::allowed(mode_i, byte_i);

  // resolve the pending escape, then the fresh byte, then the end-of-string flush
  always_comb begin
    pre_vec   = '0;
    pre_len   = '0;
    fr_vec    = '0;
    fr_len    = '0;
    fl_vec    = '0;
    fl_len    = '0;
    do_fresh  = 1'b0;
    held_mid  = held_i;
    digit_mid = digit_i;
    held_o    = held_i;
    digit_o   = digit_i;

    case (held_i)
      upe_pkg::HeldNone: begin
        do_fresh = 1'b1;
      end
      upe_pkg::HeldPct: begin
        if (hex) begin
          held_mid  = upe_pkg::HeldDigit;
          digit_mid = byte_i;
        end else begin
          // broken escape: send the percent as %25
          pre_vec   = {8'h00, upe_pkg::CharFive, upe_pkg::CharTwo, upe_pkg::CharPct};
          pre_len   = 3'd3;
          held_mid  = upe_pkg::HeldNone;
          digit_mid = '0;
          do_fresh  = 1'b1;
        end
      end
      upe_pkg::HeldDigit: begin
        if (hex) begin
          // complete escape copied unchanged
          pre_vec   = {8'h00, byte_i, digit_i, upe_pkg::CharPct};
          pre_len   = 3'd3;
          held_mid  = upe_pkg::HeldNone;
          digit_mid = '0;
        end else begin
          pre_vec   = {digit_i, upe_pkg::CharFive, upe_pkg::CharTwo, upe_pkg::CharPct};
          pre_len   = 3'd4;
          held_mid  = upe_pkg::HeldNone;
          digit_mid = '0;
          do_fresh  = 1'b1;
        end
      end
      default: begin
        held_mid  = upe_pkg::HeldNone;
        digit_mid = '0;
        do_fresh  = 1'b1;
      end
    endcase

    // fresh byte under the current mode
    if (do_fresh) begin
      if (pass) begin
        fr_vec = {16'h0000, byte_i};
        fr_len = 3'd1;
      end else if (esc_mode && (byte_i == upe_pkg::CharPct)) begin
        held_mid = upe_pkg::HeldPct;
      end else begin
        fr_vec = {upe_pkg::hex_char(byte_i[3:0]), upe_pkg::hex_char(byte_i[7:4]),
                  upe_pkg::CharPct};
        fr_len = 3'd3;
      end
    end

    held_o  = held_mid;
    digit_o = digit_mid;

    // end of string flushes what is still held
    if (last_i) begin
      case (held_mid)
        upe_pkg::HeldPct: begin
          fl_vec = {8'h00, upe_pkg::CharFive, upe_pkg::CharTwo, upe_pkg::CharPct};
          fl_len = 3'd3;
        end
        upe_pkg::HeldDigit: begin
          fl_vec = {digit_mid, upe_pkg::CharFive, upe_pkg::CharTwo, upe_pkg::CharPct};
          fl_len = 3'd4;
        end
        default: begin
          fl_len = '0;
        end
      endcase
      held_o  = upe_pkg::HeldNone;
      digit_o = '0;
    end
  end

  assign head_len = pre_len + fr_len;

  // pack the three segments back to back, first byte lowest
  assign burst_o.bytes = {24'h0, pre_vec} |
                         ({32'h0, fr_vec} << {pre_len, 3'b000}) |
                         ({24'h0, fl_vec} << {head_len, 3'b000});
  assign burst_o.len   = head_len + fl_len;
  assign burst_o.last  = last_i;

endmodule

// ----- hdl/upe_out_buf.sv -----
// result register that sends a burst out one byte per transaction
`timescale 1ns / 1ps

module upe_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  upe_pkg::upe_burst_t burst_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,
  output logic                m_axis_tlast
);

  logic [8*upe_pkg::MaxBytes-1:0] data_q;
  logic [2:0]                     cnt_q;
  logic                           last_q;
  logic                           pop;

  assign pop    = (cnt_q != 3'd0) && m_axis_tready;
  assign free_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_axis_tready);

  // remaining byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= burst_i.len;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // byte shifter, next byte always in the low bits
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= burst_i.bytes;
      last_q <= burst_i.last;
    end else if (pop) begin
      data_q <= data_q >> 8;
    end
  end

  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tdata  = data_q[7:0];
  assign m_axis_tlast  = last_q && (cnt_q == 3'd1);

endmodule

// ----- hdl/uri_percent_encoder_modes_core.sv -----
// URI percent encoder with six character-class modes
`timescale 1ns / 1ps
//
// Input stream s_axis_*: one string byte per transaction, tlast on the final byte.
// Output stream m_axis_*: encoded bytes, tlast on the final byte of the string.
// cfg_*: writes the 3-bit mode (0 user, 1 header, 2 password, 3 host,
//   4 token, 5 ttl digits, 6 and 7 as token); cfg_ready_o is always high.
//   Write it only while the stream is idle.
// An accepted byte is held in the input register, where it is expanded
// into zero to seven encoded bytes that load the output register once it
// is free; the output register then offers them on m_axis.
// The output register sends one byte per cycle while the receiver is ready.
// The encoded length of an input byte is 1 for a passed byte, 3 for an
// escaped byte, 0 to 7 when a pending escape resolves.
// A new byte is taken while the last byte of the previous burst goes out.
// When the receiver stalls, the output holds its byte and the input register
// fills, then s_axis_tready drops until the burst drains.
// Reset clears the mode to user, the pending escape and both registers.
//
module uri_percent_encoder_modes_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_data_i,     // [2:0] char_class_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  logic [2:0]          mode_q;
  logic                in_vld_q;
  logic [7:0]          in_byte_q;
  logic                in_last_q;
  upe_pkg::upe_held_e  held_q;
  upe_pkg::upe_held_e  held_d;
  logic [7:0]          digit_q;
  logic [7:0]          digit_d;
  upe_pkg::upe_burst_t burst;
  logic                buf_free;
  logic                take;

  assign cfg_ready_o   = 1'b1;
  assign take          = in_vld_q && buf_free;
  assign s_axis_tready = !in_vld_q || buf_free;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= upe_pkg::ModeUser;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // pending escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= upe_pkg::HeldNone;
      digit_q <= '0;
    end else if (take) begin
      held_q  <= held_d;
      digit_q <= digit_d;
    end
  end

  upe_expand u_expand (
    .mode_i  (mode_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .held_i  (held_q),
    .digit_i (digit_q),
    .held_o  (held_d),
    .digit_o (digit_d),
    .burst_o (burst)
  );

  upe_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .burst_i       (burst),
    .free_o        (buf_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- hdl/upe_checker.sv -----
// port-level checks of the percent encoder, bound to the top level
`timescale 1ns / 1ps
`include "uri_percent_encoder_modes_core_assert.svh"

module upe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // a stalled output transaction keeps its byte and marker
  `UPE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // input backpressure only while a burst waits at the output
  `UPE_ASSERT_IMPL(a_bp_needs_output, !s_axis_tready, m_axis_tvalid)

  // the final byte of a string always yields output
  `UPE_ASSERT_NEXT(a_last_yields, s_axis_tvalid && s_axis_tready && s_axis_tlast, ##1 m_axis_tvalid)

  // configuration channel never stalls
  `UPE_ASSERT_IMPL(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind uri_percent_encoder_modes_core upe_checker u_upe_checker (.*);

// ----- verif/tb_uri_percent_encoder_modes_core.sv -----
// self-checking testbench for the six-mode URI percent encoder core
`timescale 1ns / 1ps

module tb_uri_percent_encoder_modes_core;

  // the two unused mode codes, which behave as token mode
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseBytes   = 16;
  localparam int unsigned MaxReports   = 10;
  localparam longint      TimeoutNs    = 2_000_000;

  // one encoded byte as it leaves the core
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_beat_t;

  // one directed row; an empty text means the predictor supplies the bytes
  typedef struct {
    logic [2:0] mode;
    logic [7:0] data;
    logic       last;
    string      text;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_data_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  // predictor state
  logic [2:0] cur_mode;
  logic [1:0] pend_cnt;
  logic [7:0] pend_digit;
  enc_beat_t  step_q [$];
  enc_beat_t  enc_expect_q [$];

  // stall control and run statistics
  logic        tx_steady;
  logic        rx_steady;
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned mode_writes;

  stim_row_t dir_rows [26] = '{
    '{upe_pkg::ModeUser,     "a",    1'b1, "a"},
    '{upe_pkg::ModeUser,     8'h00,  1'b1, "%00"},
    '{upe_pkg::ModeUser,     8'hFF,  1'b1, "%FF"},
    '{upe_pkg::ModeUser,     "%",    1'b0, ""},
    '{upe_pkg::ModeUser,     "a",    1'b0, ""},
    '{upe_pkg::ModeUser,     "3",    1'b1, ""},
    '{upe_pkg::ModeUser,     "%",    1'b0, ""},
    '{upe_pkg::ModeUser,     "G",    1'b1, ""},
    '{upe_pkg::ModeUser,     "%",    1'b0, ""},
    '{upe_pkg::ModeUser,     "B",    1'b0, ""},
    '{upe_pkg::ModeUser,     "%",    1'b0, ""},
    '{upe_pkg::ModeUser,     "4",    1'b0, ""},
    '{upe_pkg::ModeUser,     "1",    1'b1, ""},
    '{upe_pkg::ModeUser,     "%",    1'b1, "%25"},
    '{upe_pkg::ModeHeader,   "[",    1'b1, "["},
    '{upe_pkg::ModeHeader,   "&",    1'b1, "%26"},
    '{upe_pkg::ModePassword, ",",    1'b1, ","},
    '{upe_pkg::ModePassword, ";",    1'b1, "%3B"},
    '{upe_pkg::ModePassword, "%",    1'b0, ""},
    '{upe_pkg::ModeHost,     "4",    1'b0, ""},
    '{upe_pkg::ModeHost,     "1",    1'b1, ""},
    '{upe_pkg::ModeHost,     "_",    1'b1, "%5F"},
    '{upe_pkg::ModeToken,    "%",    1'b1, "%"},
    '{upe_pkg::ModeTtl,      "a",    1'b1, "%61"},
    '{ModeSpare7,            "%",    1'b1, "%"},
    '{ModeSpare6,            8'h80,  1'b1, "%80"}
  };

  logic [2:0] phase_modes [9] = '{
    upe_pkg::ModeUser, upe_pkg::ModeTtl, upe_pkg::ModeHeader, ModeSpare7,
    upe_pkg::ModePassword, upe_pkg::ModeHost, upe_pkg::ModeToken, ModeSpare6,
    upe_pkg::ModeUser
  };

  uri_percent_encoder_modes_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),     // [2:0] char_class_mode
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // character class tables
  function automatic logic in_list(input logic [7:0] c, input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic byte_passes(input logic [2:0] mode, input logic [7:0] c);
    logic alnum;
    logic mark;
    alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    mark  = alnum || in_list(c, "-_.!~*'()");
    case (mode)
      upe_pkg::ModeUser:     return mark || in_list(c, "&=+$,;?/");
      upe_pkg::ModeHeader:   return mark || in_list(c, "[]/?:+$");
      upe_pkg::ModePassword: return mark || in_list(c, "&=+$,");
      upe_pkg::ModeHost:     return alnum || in_list(c, ".:[]-");
      upe_pkg::ModeTtl:      return c >= "0" && c <= "9";
      default:               return alnum || in_list(c, "-.!%*_+`'~");
    endcase
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n) - 8'd10;
  endfunction

  // predictor: expands one byte into step_q
  function automatic void put_beat(input logic [7:0] b);
    step_q.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void put_escaped(input logic [7:0] b);
    put_beat(upe_pkg::CharPct);
    put_beat(nibble_char(b[7:4]));
    put_beat(nibble_char(b[3:0]));
  endfunction

  function automatic void encode_fresh(input logic [7:0] b);
    if (byte_passes(cur_mode, b)) begin
      put_beat(b);
    end else if (cur_mode <= upe_pkg::ModePassword && b == upe_pkg::CharPct) begin
      pend_cnt = 2'd1;
    end else begin
      put_escaped(b);
    end
  endfunction

  // a pending escape that did not complete goes out as %25, plus its digit if one was held
  function automatic void flush_pending();
    if (pend_cnt >= 2'd1) put_escaped(upe_pkg::CharPct);
    if (pend_cnt >= 2'd2) put_beat(pend_digit);
    pend_cnt   = 2'd0;
    pend_digit = 8'h00;
  endfunction

  function automatic void encode_step(input logic [7:0] b, input logic last);
    step_q.delete();
    if (pend_cnt == 2'd1 && is_hex_char(b)) begin
      pend_cnt   = 2'd2;
      pend_digit = b;
    end else if (pend_cnt >= 2'd2 && is_hex_char(b)) begin
      put_beat(upe_pkg::CharPct);
      put_beat(pend_digit);
      put_beat(b);
      pend_cnt   = 2'd0;
      pend_digit = 8'h00;
    end else begin
      flush_pending();
      encode_fresh(b);
    end
    if (last) begin
      flush_pending();
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    end
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input logic steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_allowed(input logic [2:0] mode);
    logic [7:0] c;
    for (int i = 0; i < 40; i++) begin
      c = 8'($urandom_range(1, 255));
      if (byte_passes(mode, c)) return c;
    end
    return "7";
  endfunction

  function automatic logic [7:0] pick_hex();
    string digits;
    digits = "0123456789ABCDEFabcdef";
    return digits[$urandom_range(0, 21)];
  endfunction

  // one input transaction, called at a falling edge
  task automatic drive_item(input logic [7:0] b, input logic last, input string text);
    int gap;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_step(b, last);
    if (text.len() != 0) begin
      for (int j = 0; j < text.len(); j++) begin
        enc_expect_q.push_back('{data: text[j], last: logic'(j == text.len() - 1)});
      end
    end else begin
      foreach (step_q[j]) enc_expect_q.push_back(step_q[j]);
    end
    items_sent++;
    gap = pick_gap(tx_steady);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (enc_expect_q.size() != 0) @(negedge clk_i);
  endtask

  // mode write, only with the stream drained
  task automatic write_mode(input logic [2:0] m);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_mode = m;
    mode_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // receiver with random stalls
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int gap;
      gap = pick_gap(rx_steady);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // compare every output transaction with the oldest expected byte
  always @(posedge clk_i) begin : out_check
    enc_beat_t got;
    enc_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{data: m_axis_tdata, last: m_axis_tlast};
      if (enc_expect_q.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("unexpected output byte %h last %b", got.data, got.last);
      end else begin
        want = enc_expect_q.pop_front();
        beats_checked++;
        if (got != want) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.data, want.last, got.data, got.last);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] str_q [$];
    int         str_len;
    int         phase_count;
    int         k;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = upe_pkg::ModeUser;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    cur_mode      = upe_pkg::ModeUser;
    pend_cnt      = 2'd0;
    pend_digit    = 8'h00;
    err_count     = 0;
    items_sent    = 0;
    beats_checked = 0;
    mode_writes   = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows; the first ones run in the reset mode
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) write_mode(dir_rows[i].mode);
      drive_item(dir_rows[i].data, dir_rows[i].last, dir_rows[i].text);
    end

    // random strings, mostly escapes and class bytes, some noise
    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      tx_steady   = ($urandom_range(0, 3) == 0);
      rx_steady   = ($urandom_range(0, 3) == 0);
      phase_count = 0;
      while (phase_count < PhaseBytes) begin
        str_q.delete();
        str_len = $urandom_range(1, 10);
        while (str_q.size() < str_len) begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              str_q.push_back(upe_pkg::CharPct);
              str_q.push_back(pick_hex());
              str_q.push_back(pick_hex());
            end
            3: begin
              str_q.push_back(upe_pkg::CharPct);
              str_q.push_back(pick_hex());
            end
            4: str_q.push_back(upe_pkg::CharPct);
            5, 6, 7: str_q.push_back(pick_allowed(cur_mode));
            default: str_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        for (k = 0; k < str_q.size(); k++) begin
          drive_item(str_q[k], logic'(k == str_q.size() - 1), "");
        end
        phase_count += str_q.size();
        // hold off now and then until the output has caught up
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    $display("run covered %0d input bytes over %0d mode writes, all eight mode codes",
             items_sent, mode_writes);
    $display("%0d encoded bytes checked, %0d errors", beats_checked, err_count);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutNs);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
